FILE: hw/rtl/idma_pkg.sv
`timescale 1ns / 1ps
package idma_pkg;

  localparam logic [1:0] MD_WRITE  = 2'd0;
  localparam logic [1:0] MD_READ   = 2'd1;
  localparam logic [1:0] MD_UPDATE = 2'd2;

  localparam logic [3:0] FF_IDX    = 4'd12;
  localparam logic [7:0] MODE_AUTO = 8'h10;
  localparam logic [15:0] ALL_ONES = 16'hffff;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic exec;
    logic finish;
  } idma_cmd_t;

  typedef struct packed {
    logic done;
  } idma_stat_t;

  // Page register offset to channel; bit 3 flags a port with no channel.
  function automatic logic [3:0] page_map(input logic [3:0] off);
    logic [3:0] r;
    case (off)
      4'h1: r = 4'd2;
      4'h2: r = 4'd3;
      4'h3: r = 4'd1;
      4'h7: r = 4'd0;
      4'h9: r = 4'd6;
      4'ha: r = 4'd7;
      4'hb: r = 4'd5;
      4'hf: r = 4'd4;
      default: r = 4'b1000;
    endcase
    return r;
  endfunction

endpackage

FILE: hw/rtl/idma_ctrl.sv
`timescale 1ns / 1ps
module idma_ctrl
  import idma_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  output idma_cmd_t  cmd,
  input  idma_stat_t stat
);

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_FIN, S_OUT} state_t;
  state_t state;

  assign in_stall = (state != S_IDLE) || (out_valid && out_stall);
  assign cmd.load = in_valid && !in_stall;
  assign cmd.exec = (state == S_EXEC);
  assign cmd.finish = (state == S_FIN);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        S_IDLE: if (cmd.load) state <= S_EXEC;
        S_EXEC: state <= S_FIN;
        S_FIN: if (stat.done) state <= S_OUT;
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: hw/rtl/idma_dp.sv
`timescale 1ns / 1ps
module idma_dp
  import idma_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  idma_cmd_t   cmd,
  output idma_stat_t  stat,
  input  logic        out_load,
  input  logic [7:0]  vmask,
  input  logic [1:0]  mode,
  input  logic [7:0]  port,
  input  logic [7:0]  data,
  input  logic [7:0]  hw_read_value,
  input  logic [2:0]  channel,
  input  logic [16:0] byte_index,
  input  logic [17:0] byte_count,
  input  logic [2:0]  emulated_channel,
  input  logic        emulated_running,
  output logic [7:0]  read_data,
  output logic        forward_to_hw,
  output logic [16:0] returned_index,
  output logic [23:0] base_address,
  output logic [17:0] remaining_bytes,
  output logic        channel_masked,
  output logic        channel_auto_init
);

  logic [15:0] pshadow [32];
  logic [7:0]  page_sh [8];
  logic [7:0]  mode_sh [8];
  logic [15:0] cur_off [8];
  logic [15:0] cur_rem [8];
  logic [15:0] base_off [8];
  logic [15:0] init_cnt [8];
  logic [7:0]  mask_bits, term_bits, mid_rd, deferred;

  // Latched item.
  logic [1:0]  r_mode;
  logic [7:0]  r_port, r_data, r_hw;
  logic [2:0]  r_ch, r_vch;
  logic [16:0] r_idx;
  logic [17:0] r_cnt;
  logic        r_run;

  // Result staging.
  logic [7:0]  rd;
  logic        fwd;
  logic [16:0] ridx;
  logic        upd_pending;
  logic [2:0]  upd_ch;
  logic [4:0]  upd_reg;

  // Decode of the latched port.
  logic       lo_ctl, hi_ctl, lo_adr, hi_adr, pg;
  logic [4:0] ctl_entry, adr_entry;
  logic [3:0] ctl_idx;
  logic [2:0] adr_ch, cb;
  logic [3:0] pg_ch;
  logic [7:0] grp;
  logic [4:0] ff_entry;
  logic       ff_odd;
  logic [3:0] rd_ch;
  logic       rd_virt;

  always_comb begin
    lo_ctl = (r_port >= 8'h08) && (r_port <= 8'h0f);
    hi_ctl = (r_port >= 8'hd0) && (r_port <= 8'hde);
    lo_adr = (r_port <= 8'h07);
    hi_adr = (r_port >= 8'hc0) && (r_port <= 8'hce);
    pg     = (r_port >= 8'h80) && (r_port <= 8'h8f);
    pg_ch  = page_map(r_port[3:0]);
    if (hi_ctl) begin
      ctl_idx = 4'd8 + {1'b0, r_port[3:1]};
      cb = 3'd4;
    end else begin
      ctl_idx = r_port[3:0];
      cb = 3'd0;
    end
    ctl_entry = {hi_ctl, ctl_idx};
    grp = hi_ctl ? 8'hf0 : 8'h0f;
    if (hi_adr) begin
      adr_entry = {2'b10, r_port[3:1]};
      adr_ch = {1'b1, r_port[3:2]};
    end else begin
      adr_entry = {2'b00, r_port[2:0]};
      adr_ch = {1'b0, r_port[2:1]};
    end
    ff_entry = {hi_adr, FF_IDX};
    ff_odd = pshadow[ff_entry][0];
    if (lo_adr || hi_adr) rd_ch = {1'b0, adr_ch};
    else if (pg) rd_ch = pg_ch;
    else rd_ch = 4'b1000;
    rd_virt = !rd_ch[3] && vmask[rd_ch[2:0]];
  end

  // Clamped address for the channel the pending update names.
  logic [16:0] lim, idxc;
  logic [15:0] clamp;
  always_comb begin
    lim  = {1'b0, init_cnt[upd_ch]} + 17'd1;
    idxc = ({1'b0, cur_off[upd_ch]} > lim) ? lim : {1'b0, cur_off[upd_ch]};
    clamp = base_off[upd_ch] + idxc[15:0];
  end

  logic [15:0] cnt_m1;
  logic [1:0]  vpos;
  logic [7:0]  st_val, tc_bit;
  always_comb begin
    cnt_m1 = 16'((r_cnt - 18'd1) >> (r_ch[2] ? 1 : 0));
    vpos = r_vch[1:0];
    tc_bit = term_bits & (8'd1 << r_vch);
    st_val = r_hw & ~(8'h11 << vpos);
    if (r_run) st_val = st_val | (8'd1 << (4 + vpos));
    st_val = st_val | (r_vch[2] ? (tc_bit >> 4) : tc_bit);
  end

  assign stat.done = 1'b1;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      r_mode <= mode; r_port <= port; r_data <= data; r_hw <= hw_read_value;
      r_ch <= channel; r_vch <= emulated_channel; r_idx <= byte_index;
      r_cnt <= byte_count; r_run <= emulated_running;
    end
    if (rst) begin
      for (int i = 0; i < 32; i++) pshadow[i] <= '0;
      for (int i = 0; i < 8; i++) begin
        page_sh[i] <= '0; mode_sh[i] <= '0; cur_off[i] <= '0; cur_rem[i] <= '0;
        base_off[i] <= '0; init_cnt[i] <= '0;
      end
      mask_bits <= '0; term_bits <= '0; mid_rd <= '0; deferred <= '0;
      upd_pending <= 1'b0;
      upd_ch <= '0; upd_reg <= '0;
      rd <= '0; fwd <= 1'b0; ridx <= '0;
    end else if (cmd.exec) begin
      rd <= '0; fwd <= 1'b0; ridx <= '0; upd_pending <= 1'b0;
      case (r_mode)
        MD_WRITE: begin
          rd <= r_data; fwd <= 1'b1;
          if (lo_ctl || hi_ctl) begin
            case (ctl_idx)
              4'ha: mask_bits[cb + {1'b0, r_data[1:0]}] <= r_data[2];
              4'hb: mode_sh[cb + {1'b0, r_data[1:0]}] <= r_data & 8'hfc;
              4'hc: pshadow[ff_entry | {hi_ctl, 4'd0}] <= '0;
              4'hd: begin
                pshadow[{hi_ctl, FF_IDX}] <= '0;
                term_bits <= term_bits & ~grp;
                mask_bits <= mask_bits | grp;
              end
              4'he: mask_bits <= mask_bits & ~grp;
              4'hf: mask_bits <= (mask_bits & ~grp) |
                                 (hi_ctl ? {r_data[3:0], 4'd0} : {4'd0, r_data[3:0]});
              default: pshadow[ctl_entry] <= {8'd0, r_data};
            endcase
          end else if (lo_adr || hi_adr) begin
            pshadow[ff_entry] <= pshadow[ff_entry] + 16'd1;
            if (!ff_odd) begin
              mid_rd[adr_ch] <= 1'b1;
              pshadow[adr_entry] <= {pshadow[adr_entry][15:8], r_data};
            end else begin
              pshadow[adr_entry] <= {r_data, pshadow[adr_entry][7:0]};
              mid_rd[adr_ch] <= 1'b0;
              deferred[adr_ch] <= 1'b0;
              if (!adr_entry[0]) begin
                cur_off[adr_ch] <= '0;
                base_off[adr_ch] <= {r_data, pshadow[adr_entry][7:0]};
              end else begin
                cur_rem[adr_ch] <= {r_data, pshadow[adr_entry][7:0]};
                init_cnt[adr_ch] <= {r_data, pshadow[adr_entry][7:0]};
              end
            end
          end else if (pg && !pg_ch[3]) begin
            page_sh[pg_ch[2:0]] <= r_data;
            cur_off[pg_ch[2:0]] <= '0;
          end
        end
        MD_READ: begin
          if (rd_virt) begin
            if (lo_adr || hi_adr) begin
              pshadow[ff_entry] <= pshadow[ff_entry] + 16'd1;
              if (!ff_odd) begin
                mid_rd[adr_ch] <= 1'b1;
                rd <= pshadow[adr_entry][7:0];
              end else begin
                rd <= pshadow[adr_entry][15:8];
                mid_rd[adr_ch] <= 1'b0;
                if (deferred[adr_ch]) begin
                  deferred[adr_ch] <= 1'b0;
                  upd_pending <= 1'b1;
                  upd_ch <= adr_ch;
                  upd_reg <= {adr_entry[4:1], 1'b0};
                end
              end
            end else begin
              rd <= page_sh[rd_ch[2:0]];
            end
          end else begin
            fwd <= 1'b1;
            if ((r_port == 8'h08 && !r_vch[2]) || (r_port == 8'hd0 && r_vch[2])) begin
              rd <= st_val;
              term_bits <= term_bits & ~tc_bit;
            end else begin
              rd <= r_hw;
            end
          end
        end
        MD_UPDATE: begin
          upd_ch <= r_ch;
          upd_reg <= {r_ch[2], 1'b0, r_ch[1:0], 1'b0};
          if (r_cnt == 18'd0) begin
            term_bits[r_ch] <= 1'b1;
            if ((mode_sh[r_ch] & MODE_AUTO) != 8'd0) begin
              cur_off[r_ch] <= '0; cur_rem[r_ch] <= init_cnt[r_ch];
              ridx <= '0;
            end else begin
              cur_off[r_ch] <= 16'(r_idx >> (r_ch[2] ? 1 : 0));
              cur_rem[r_ch] <= ALL_ONES;
              ridx <= r_ch[2] ? {r_idx[16:1], 1'b0} : {1'b0, r_idx[15:0]};
            end
          end else begin
            cur_off[r_ch] <= 16'(r_idx >> (r_ch[2] ? 1 : 0));
            cur_rem[r_ch] <= cnt_m1;
            ridx <= r_ch[2] ? {r_idx[16:1], 1'b0} : {1'b0, r_idx[15:0]};
          end
          if (mid_rd[r_ch]) deferred[r_ch] <= 1'b1;
          else upd_pending <= 1'b1;
        end
        default: ;
      endcase
    end else if (cmd.finish && upd_pending) begin
      // Refresh the address and count shadows from the progress state.
      pshadow[upd_reg] <= clamp;
      pshadow[upd_reg + 5'd1] <= cur_rem[upd_ch];
      upd_pending <= 1'b0;
    end
  end

  // Register pair for channel c: 2c for 0-3, 8+2c (entries 16..22) for 4-7.

  logic [17:0] rem_w;
  logic        size2;
  always_comb begin
    size2 = r_ch[2];
    if (cur_rem[r_ch] == ALL_ONES && term_bits[r_ch]) rem_w = '0;
    else rem_w = ({2'b0, cur_rem[r_ch]} + 18'd1) << (size2 ? 1 : 0);
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      read_data <= rd;
      forward_to_hw <= fwd;
      returned_index <= ridx;
      base_address <= {page_sh[r_ch], 16'd0} |
                      ({8'd0, base_off[r_ch]} << (size2 ? 1 : 0));
      remaining_bytes <= rem_w;
      channel_masked <= mask_bits[r_ch];
      channel_auto_init <= mode_sh[r_ch][4];
    end
  end

endmodule

FILE: hw/rtl/isa_dma_controller_shadow_core.sv
`timescale 1ns / 1ps
// Shadow of a cascaded 8237-style DMA controller pair with eight channels.
// Each transfer on the input channel is a port write, a port read or a
// progress update, and produces exactly one result. An item goes through
// capture, one state update step, a shadow refresh step that also loads
// the output register, and raising the output valid; the sequencer handles
// one item at a time, and a stalled result holds off the next input.
// The virtualized channel mask may be written only while the block is idle.
module isa_dma_controller_shadow_core
  import idma_pkg::*;
#(
  parameter int NUM_CHANNELS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [NUM_CHANNELS-1:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  mode,
  input  logic [7:0]  port,
  input  logic [7:0]  data,
  input  logic [7:0]  hw_read_value,
  input  logic [2:0]  channel,
  input  logic [16:0] byte_index,
  input  logic [17:0] byte_count,
  input  logic [2:0]  emulated_channel,
  input  logic        emulated_running,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  read_data,
  output logic        forward_to_hw,
  output logic [16:0] returned_index,
  output logic [23:0] base_address,
  output logic [17:0] remaining_bytes,
  output logic        channel_masked,
  output logic        channel_auto_init
);

  logic [7:0] vmask;
  idma_cmd_t  cmd;
  idma_stat_t stat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) vmask <= '0;
    else if (cfg_valid) vmask <= 8'(cfg_data);
  end

  idma_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .cmd(cmd), .stat(stat)
  );

  idma_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .out_load(cmd.finish), .vmask(vmask),
    .mode(mode), .port(port), .data(data), .hw_read_value(hw_read_value),
    .channel(channel), .byte_index(byte_index), .byte_count(byte_count),
    .emulated_channel(emulated_channel), .emulated_running(emulated_running),
    .read_data(read_data), .forward_to_hw(forward_to_hw),
    .returned_index(returned_index), .base_address(base_address),
    .remaining_bytes(remaining_bytes), .channel_masked(channel_masked),
    .channel_auto_init(channel_auto_init)
  );

endmodule
